FILE: hw/rtl/cctp_pkg.sv
// Package for the command complete tag parser: beat and result types,
// character codes, keyword table and the whitespace test.
// No dependencies.
`default_nettype none

package cctp_pkg;

   localparam int NUM_KW          = 8;
   localparam int KW_SELECT_COUNT = 3;
   localparam int FIRST_MAX       = 6;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // first character in the lowest byte, unused bytes zero
   localparam logic [47:0] KW_CHARS [NUM_KW] = '{
      48'h5443_454C_4553,   // SELECT
      48'h0048_4354_4546,   // FETCH
      48'h0000_4556_4F4D,   // MOVE
      48'h5452_4553_4E49,   // INSERT
      48'h4554_4144_5055,   // UPDATE
      48'h4554_454C_4544,   // DELETE
      48'h0000_5950_4F43,   // COPY
      48'h0045_4752_454D    // MERGE
   };
   localparam logic [2:0] KW_LEN [NUM_KW] = '{
      3'd6, 3'd5, 3'd4, 3'd6, 3'd6, 3'd6, 3'd4, 3'd5
   };

   typedef enum logic [1:0] {
      PHASE_LEAD,
      PHASE_FIRST,
      PHASE_SPACE,
      PHASE_COUNT
   } phase_type;

   typedef enum logic [1:0] {
      STEP_WS,
      STEP_SIGN,
      STEP_DIGITS,
      STEP_ENDED
   } step_type;

   typedef struct packed {
      logic     invalid;
      logic     neg;
      step_type step;
   } tok_status_type;

   localparam tok_status_type TOK_IDLE = '{invalid: 1'b0, neg: 1'b0, step: STEP_WS};

   typedef struct packed {
      logic [63:0]    value;
      tok_status_type status;
   } tok_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } beat_type;

   typedef struct packed {
      logic [63:0] row_count;
      logic        select_like;
   } result_type;

   function automatic logic is_ws(logic [7:0] b);
      return (b inside {CH_SPACE, [CH_TAB:CH_CR]});
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cctp_in_reg.sv
// Input register of the command complete tag parser: holds one request beat
// until the parse stage takes it. Depends on cctp_pkg.
`default_nettype none

module cctp_in_reg
   import cctp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire beat_type req_beat,
   output logic          beat_vld,
   output beat_type      beat,
   input  wire logic     take
);

   logic     vld_ff, vld_in;
   beat_type beat_ff, beat_in;

   always_comb begin
      req_ready = !vld_ff || take;
      vld_in    = req_valid || (vld_ff && !take);
      beat_in   = (req_valid && req_ready) ? req_beat : beat_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      beat_ff <= beat_in;
   end

   assign beat_vld = vld_ff;
   assign beat     = beat_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/cctp_parse.sv
// Parse stage of the command complete tag parser: per-byte scan state, count
// accumulator, keyword match; one beat per cycle bar stalls. Depends on cctp_pkg.
`default_nettype none

module cctp_parse
   import cctp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     beat_vld,
   input  wire beat_type beat,
   input  wire logic     out_free,
   output logic          take,
   output logic          load,
   output result_type    result
);

   phase_type      phase_ff, phase_in;
   logic [47:0]    chars_ff, chars_in, app_chars;
   logic [2:0]     len_ff, len_in, app_len;
   tok_type        ten_ff, ten_in, ten_adv;
   tok_type        com_ff, com_in;
   logic [7:0]     b;
   logic           ws;
   logic           hit;
   logic           sel;

   function automatic tok_type tok_advance(tok_type t, logic [7:0] c);
      tok_type     r;
      logic [63:0] base;
      logic [67:0] acc;
      r    = t;
      base = (t.status.step == STEP_DIGITS) ? t.value : 64'd0;
      acc  = {4'b0, base} * 68'd10 + {64'b0, c[3:0]};
      if (t.status.invalid || t.status.step == STEP_ENDED) begin
         r = t;
      end else if (c inside {[CH_ZERO:CH_NINE]}) begin
         r.status.step = STEP_DIGITS;
         if (acc[67:64] != 4'd0) begin
            r.value      = '1;
            r.status.neg = 1'b0;
         end else begin
            r.value = acc[63:0];
         end
      end else if (t.status.step == STEP_DIGITS) begin
         if (c == CH_NUL) begin
            r.status.step = STEP_ENDED;
         end else begin
            r.status.invalid = 1'b1;
         end
      end else if (t.status.step == STEP_WS && c == CH_PLUS) begin
         r.status = '{invalid: 1'b0, neg: 1'b0, step: STEP_SIGN};
      end else if (t.status.step == STEP_WS && c == CH_MINUS) begin
         r.status = '{invalid: 1'b0, neg: 1'b1, step: STEP_SIGN};
      end else if (t.status.step == STEP_WS && c != CH_NUL && is_ws(c)) begin
         r = t;
      end else begin
         r.status.invalid = 1'b1;
      end
      return r;
   endfunction

   assign b    = beat.data_byte;
   assign ws   = is_ws(b);
   assign take = beat_vld && (!beat.last_byte || out_free);
   assign load = take && beat.last_byte;

   // append to the first token, mark too long past six bytes
   always_comb begin
      app_chars = chars_ff;
      app_len   = 3'd7;
      if (len_ff < 3'(FIRST_MAX)) begin
         for (int i = 0; i < FIRST_MAX; i++) begin
            if (len_ff == 3'(i)) begin
               app_chars[8*i +: 8] = b;
            end
         end
         app_len = len_ff + 3'd1;
      end
   end

   assign ten_adv = tok_advance(ten_ff, b);

   always_comb begin
      phase_in = phase_ff;
      chars_in = chars_ff;
      len_in   = len_ff;
      ten_in   = ten_ff;
      com_in   = com_ff;
      case (phase_ff)
         PHASE_LEAD: begin
            if (!ws) begin
               phase_in = PHASE_FIRST;
               chars_in = app_chars;
               len_in   = app_len;
            end
         end
         PHASE_FIRST: begin
            if (b == CH_SPACE) begin
               phase_in = PHASE_SPACE;
               ten_in   = '{value: 64'd0, status: TOK_IDLE};
            end else begin
               chars_in = app_chars;
               len_in   = app_len;
            end
         end
         PHASE_SPACE, PHASE_COUNT: begin
            if (b == CH_SPACE) begin
               ten_in = '{value: 64'd0, status: TOK_IDLE};
            end else begin
               ten_in = ten_adv;
            end
            if (b != CH_NUL && !ws) begin
               com_in   = ten_in;
               phase_in = PHASE_COUNT;
            end
         end
         default: begin
            phase_in = PHASE_LEAD;
         end
      endcase
   end

   // the first token is final once the count phase is reached
   always_comb begin
      hit = 1'b0;
      sel = 1'b0;
      for (int k = 0; k < NUM_KW; k++) begin
         if (!hit && len_ff == KW_LEN[k] && chars_ff == KW_CHARS[k]) begin
            hit = 1'b1;
            sel = (k < KW_SELECT_COUNT);
         end
      end
   end

   always_comb begin
      result.row_count   = 64'd0;
      result.select_like = 1'b0;
      if (phase_in == PHASE_COUNT && hit) begin
         result.select_like = sel;
         if (!com_in.status.invalid &&
             (com_in.status.step == STEP_DIGITS || com_in.status.step == STEP_ENDED)) begin
            result.row_count = com_in.status.neg ? (64'd0 - com_in.value) : com_in.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || load) begin
         phase_ff <= PHASE_LEAD;
         chars_ff <= 48'd0;
         len_ff   <= 3'd0;
         ten_ff   <= '{value: 64'd0, status: TOK_IDLE};
         com_ff   <= '{value: 64'd0, status: TOK_IDLE};
      end else if (take) begin
         phase_ff <= phase_in;
         chars_ff <= chars_in;
         len_ff   <= len_in;
         ten_ff   <= ten_in;
         com_ff   <= com_in;
      end
   end

   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      load |=> (phase_ff == PHASE_LEAD))
      else $error("scan state not cleared after last beat");

   a_lead_empty_token: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PHASE_LEAD) |-> (len_ff == 3'd0 && chars_ff == 48'd0))
      else $error("first token not empty while skipping leading whitespace");

   a_commit_only_in_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PHASE_COUNT) |-> (com_ff.value == 64'd0 && com_ff.status == TOK_IDLE))
      else $error("count committed before count phase");

endmodule

`default_nettype wire

FILE: hw/rtl/cctp_out_reg.sv
// Result register of the command complete tag parser: holds one response
// beat until the consumer takes it. Depends on cctp_pkg.
`default_nettype none

module cctp_out_reg
   import cctp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire result_type result,
   output logic            out_free,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output result_type      rsp_result
);

   logic       vld_ff, vld_in;
   result_type res_ff, res_in;

   always_comb begin
      out_free = !vld_ff || rsp_ready;
      vld_in   = load || (vld_ff && !rsp_ready);
      res_in   = load ? result : res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      res_ff <= res_in;
   end

   assign rsp_valid  = vld_ff;
   assign rsp_result = res_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/command_complete_tag_parser_unit.sv
// Top level of the command complete tag parser: input register, parse stage
// and result register. Depends on cctp_pkg, cctp_in_reg, cctp_parse, cctp_out_reg.
//
//   channel | ports                                             | beat
//   req     | req_valid req_ready req_data_byte req_last_byte   | one tag byte
//   rsp     | rsp_valid rsp_ready rsp_row_count rsp_select_like | one per tag
//
// One byte per cycle sustained while the result register can accept; a byte
// reaches the parse stage the cycle after acceptance, and taking its last byte
// registers the response. The per-cycle path is the 64-bit multiply-by-ten
// accumulate in the parse stage. Synchronous active-high reset clears the scan
// state and both valid flags. A stalled response holds only a last byte in the
// input register; earlier bytes of a tag keep flowing.
`default_nettype none

module command_complete_tag_parser_unit
   import cctp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_row_count,
   output logic             rsp_select_like
);

   beat_type   req_beat;
   beat_type   beat;
   logic       beat_vld;
   logic       take;
   logic       load;
   logic       out_free;
   result_type result;
   result_type rsp_result;

   assign req_beat.data_byte = req_data_byte;
   assign req_beat.last_byte = req_last_byte;

   cctp_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_beat  (req_beat),
      .beat_vld  (beat_vld),
      .beat      (beat),
      .take      (take)
   );

   cctp_parse u_parse (
      .clock    (clock),
      .reset    (reset),
      .beat_vld (beat_vld),
      .beat     (beat),
      .out_free (out_free),
      .take     (take),
      .load     (load),
      .result   (result)
   );

   cctp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .result     (result),
      .out_free   (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   assign rsp_row_count   = rsp_result.row_count;
   assign rsp_select_like = rsp_result.select_like;

endmodule

`default_nettype wire
